[design/rtpl_pkg.sv]
// Package with shared types, codes and constants of the route table.
`default_nettype none
package rtpl_pkg;

    localparam int ENTRIES_DEFAULT = 64;

    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_EXACT  = 3'd2;
    localparam logic [2:0] OP_LPM    = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    // One stored route.
    typedef struct packed {
        logic [31:0] address;
        logic [5:0]  prefix;
        logic [31:0] next_hop;
        logic [15:0] distance;
        logic        broken;
    } route_t;

    // Request item on the input channel.
    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] address;
        logic [5:0]  prefix_len;
        logic [31:0] next_hop;
        logic [15:0] distance;
        logic        broken_in;
        logic [5:0]  slot;
    } rtpl_req_t;

    // Result item on the output channel.
    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  hit_slot;
        logic [31:0] hit_address;
        logic [5:0]  hit_prefix;
        logic [31:0] hit_next_hop;
        logic [15:0] hit_distance;
        logic        hit_broken;
        logic [6:0]  entry_count;
    } rtpl_rsp_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture the input item
        logic scan_rd;   // read the entry at the scan index
        logic compare;   // evaluate the entry read in the last cycle
        logic step;      // advance the scan index
        logic write_new; // write the captured route at the fill count
        logic shift_wr;  // write the entry read last cycle one slot lower
        logic dec_count;
        logic inc_count;
        logic fetch_hit; // read the found entry for the result
        logic finish;    // build the result
    } rtpl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic [2:0] opcode;
        logic       full;
        logic       scan_last; // scan index is at the last used entry
        logic       empty;
        logic       found;     // a delete or exact match was seen
        logic       read_ok;
    } rtpl_sts_t;

endpackage
`default_nettype wire

[design/rtpl_if.sv]
// Valid/ready channel interface carrying one payload type.
`default_nettype none
interface rtpl_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/rtpl_ctrl.sv]
// Controller state machine that sequences scans, shifts and results.
`default_nettype none
module rtpl_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire rtpl_pkg::rtpl_sts_t sts,
    output rtpl_pkg::rtpl_cmd_t    cmd
);
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DISP   = 7'b0000010,
        S_SCAN   = 7'b0000100,
        S_SHIFT  = 7'b0001000,
        S_FETCH  = 7'b0010000,
        S_FIN    = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   rd_pend_reg, rd_pend_next; // an entry read is in flight

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        rd_pend_next = 1'b0;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (sts.opcode)
                    rtpl_pkg::OP_APPEND:
                    begin
                        if (!sts.full)
                        begin
                            cmd.write_new = 1'b1;
                            cmd.inc_count = 1'b1;
                            state_next    = S_FETCH;
                        end
                        else
                            state_next = S_FIN;
                    end
                    rtpl_pkg::OP_DELETE, rtpl_pkg::OP_EXACT, rtpl_pkg::OP_LPM:
                    begin
                        if (sts.empty)
                            state_next = S_FIN;
                        else
                        begin
                            cmd.scan_rd  = 1'b1;
                            rd_pend_next = 1'b1;
                            state_next   = S_SCAN;
                        end
                    end
                    rtpl_pkg::OP_READ:
                        state_next = sts.read_ok ? S_FETCH : S_FIN;
                    default:
                        state_next = S_FIN;
                endcase
            end
            S_SCAN:
            begin
                // The entry at the scan index was read last cycle.
                cmd.compare = 1'b1;
                if (sts.found || sts.scan_last)
                begin
                    if (sts.found && sts.opcode == rtpl_pkg::OP_DELETE)
                    begin
                        cmd.step   = !sts.scan_last;
                        cmd.scan_rd = !sts.scan_last;
                        rd_pend_next = !sts.scan_last;
                        state_next = S_SHIFT;
                    end
                    else
                        state_next = S_FETCH;
                end
                else
                begin
                    cmd.step     = 1'b1;
                    cmd.scan_rd  = 1'b1;
                    rd_pend_next = 1'b1;
                end
            end
            S_SHIFT:
            begin
                // Move the entries behind the deleted one up one slot.
                if (rd_pend_reg)
                begin
                    cmd.shift_wr = 1'b1;
                    if (!sts.scan_last)
                    begin
                        cmd.step     = 1'b1;
                        cmd.scan_rd  = 1'b1;
                        rd_pend_next = 1'b1;
                    end
                end
                else
                begin
                    cmd.dec_count = 1'b1;
                    state_next    = S_FIN;
                end
            end
            S_FETCH:
            begin
                cmd.fetch_hit = 1'b1;
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    // A result is never shown while a new item can enter.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready and result valid together");
    // A held result stays until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    // Shifts only follow a read.
    a_shift: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_wr |-> $past(cmd.scan_rd)) else $error("shift without read");
endmodule
`default_nettype wire

[design/rtpl_dp.sv]
// Datapath: route memory, scan index, match logic and result register.
`default_nettype none
module rtpl_dp #(
    parameter int ENTRIES = rtpl_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [2:0]          opcode,
    input  wire logic [31:0]         address,
    input  wire logic [5:0]          prefix_len,
    input  wire logic [31:0]         next_hop,
    input  wire logic [15:0]         distance,
    input  wire logic                broken_in,
    input  wire logic [5:0]          slot,
    input  wire rtpl_pkg::rtpl_cmd_t cmd,
    output rtpl_pkg::rtpl_sts_t      sts,
    output logic [1:0]               status,
    output logic [5:0]               hit_slot,
    output rtpl_pkg::route_t         hit,
    output logic [6:0]               entry_count
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    rtpl_pkg::route_t mem [ENTRIES];

    logic [2:0]       op_reg;
    logic [31:0]      key_reg;
    rtpl_pkg::route_t new_reg;
    logic [5:0]       slot_reg;
    logic [CW-1:0]    count_reg;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [IW-1:0]    best_reg;
    logic [5:0]       blen_reg;
    logic             bfound_reg;
    rtpl_pkg::route_t rd_reg;
    rtpl_pkg::route_t fetch_reg;
    rtpl_pkg::route_t fetch_hold;
    logic [IW-1:0]    rd_addr;
    logic [31:0]      mask;
    logic             addr_eq, covers, better;
    logic             read_ok, bfound_or_append, was_full_reg;

    // Prefix match on the entry just read.
    always_comb
    begin
        mask    = (rd_reg.prefix >= 6'd32) ? 32'hFFFF_FFFF :
                  ~(32'hFFFF_FFFF >> rd_reg.prefix);
        addr_eq = (rd_reg.address == key_reg);
        covers  = ((key_reg & mask) == (rd_reg.address & mask));
        better  = (rd_reg.prefix > blen_reg) && covers;
    end

    assign idx_next = cmd.step ? idx_reg + 1'b1 : idx_reg;

    // Read address: scan position, requested slot, newly appended entry or the final hit.
    always_comb
    begin
        if (cmd.scan_rd)
            rd_addr = idx_next;
        else if (op_reg == rtpl_pkg::OP_READ)
            rd_addr = IW'(slot_reg);
        else if (op_reg == rtpl_pkg::OP_APPEND)
            rd_addr = count_reg[IW-1:0] - 1'b1;
        else
            rd_addr = best_reg;
    end

    // Route memory with a registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.write_new)
            mem[count_reg[IW-1:0]] <= new_reg;
        else if (cmd.shift_wr)
            mem[idx_reg - 1'b1] <= rd_reg;
        rd_reg <= mem[rd_addr];
    end

    assign fetch_reg = rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.inc_count)
            count_reg <= count_reg + 1'b1;
        else if (cmd.dec_count)
            count_reg <= count_reg - 1'b1;
    end

    // Scan state and captured item.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= opcode;
            key_reg  <= address;
            new_reg  <= '{address, prefix_len, next_hop, distance, broken_in};
            slot_reg <= slot;
            idx_reg  <= '0;
            blen_reg <= '0;
            bfound_reg <= 1'b0;
            best_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.compare)
            begin
                if ((op_reg == rtpl_pkg::OP_LPM) ? better : addr_eq)
                begin
                    best_reg   <= idx_reg;
                    bfound_reg <= 1'b1;
                    if (op_reg == rtpl_pkg::OP_LPM)
                        blen_reg <= rd_reg.prefix;
                    if (op_reg == rtpl_pkg::OP_DELETE)
                        fetch_hold <= rd_reg;
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status   <= rtpl_pkg::ST_OK;
            hit_slot <= '0;
            hit      <= '0;
            entry_count <= 7'(count_reg);
            case (op_reg)
                rtpl_pkg::OP_APPEND:
                    if (bfound_or_append)
                    begin
                        hit_slot <= 6'(count_reg - 1'b1);
                        hit      <= fetch_reg;
                    end
                    else
                        status <= rtpl_pkg::ST_FULL;
                rtpl_pkg::OP_DELETE:
                    if (bfound_reg)
                    begin
                        hit_slot <= 6'(best_reg);
                        hit      <= fetch_hold;
                    end
                    else
                        status <= rtpl_pkg::ST_NOTFOUND;
                rtpl_pkg::OP_EXACT, rtpl_pkg::OP_LPM:
                    if (bfound_reg)
                    begin
                        hit_slot <= 6'(best_reg);
                        hit      <= fetch_reg;
                    end
                    else
                        status <= rtpl_pkg::ST_NOTFOUND;
                rtpl_pkg::OP_READ:
                    if (read_ok)
                    begin
                        hit_slot <= slot_reg;
                        hit      <= fetch_reg;
                    end
                    else
                        status <= rtpl_pkg::ST_RANGE;
                default:
                    status <= rtpl_pkg::ST_OK;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            was_full_reg <= (count_reg >= CW'(ENTRIES));
    end

    assign read_ok          = ({{(32-6){1'b0}}, slot_reg} < 32'(count_reg));
    assign bfound_or_append = !was_full_reg;

    // Status toward the controller.
    always_comb
    begin
        sts.opcode    = op_reg;
        sts.full      = (count_reg >= CW'(ENTRIES));
        sts.empty     = (count_reg == '0);
        sts.scan_last = (CW'(idx_reg) + 1'b1 >= count_reg);
        sts.found     = (op_reg != rtpl_pkg::OP_LPM) && addr_eq;
        sts.read_ok   = read_ok;
    end

    // The fill count never passes the table depth.
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ENTRIES)) else $error("count overflow");
    // An append never happens on a full table.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_new |-> !sts.full) else $error("append when full");
    // A decrement never happens on an empty table.
    a_dec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dec_count |-> !sts.empty) else $error("delete when empty");
endmodule
`default_nettype wire

[design/route_table_prefix_lookup.sv]
// Top level of the route table with prefix lookup.
// Items are handled one at a time: a new item is taken only after the last result
// has been taken. Append and read need no scan, lookups scan the stored entries one
// by one, and delete scans to the hit, then makes one shift per following entry.
`default_nettype none
module route_table_prefix_lookup #(
    parameter int ENTRIES = rtpl_pkg::ENTRIES_DEFAULT
) (
    input wire logic clk,
    input wire logic rst_n,
    rtpl_if.sink     req,
    rtpl_if.source   rsp
);
    rtpl_pkg::rtpl_cmd_t cmd;
    rtpl_pkg::rtpl_sts_t sts;
    rtpl_pkg::route_t    hit;
    logic [1:0]          status;
    logic [5:0]          hit_slot;
    logic [6:0]          entry_count;

    rtpl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rtpl_dp #(.ENTRIES(ENTRIES)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .opcode      (req.data.opcode),
        .address     (req.data.address),
        .prefix_len  (req.data.prefix_len),
        .next_hop    (req.data.next_hop),
        .distance    (req.data.distance),
        .broken_in   (req.data.broken_in),
        .slot        (req.data.slot),
        .cmd         (cmd),
        .sts         (sts),
        .status      (status),
        .hit_slot    (hit_slot),
        .hit         (hit),
        .entry_count (entry_count)
    );

    // Pack the result fields into the output item.
    assign rsp.data = {status, hit_slot, hit.address, hit.prefix, hit.next_hop,
                       hit.distance, hit.broken, entry_count};
endmodule
`default_nettype wire

[dv/route_table_prefix_lookup_test.sv]
// Self-checking testbench for the route table with exact and longest-prefix lookup.
`default_nettype none
module route_table_prefix_lookup_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROUTE_SLOTS = 64;
    localparam int IDLE_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 730;
    localparam int QUIET_ITEMS = 100;

    // Shadow route table that predicts every response and checks it in order.
    class RouteScoreboard;
        rtpl_pkg::route_t    routes[ROUTE_SLOTS];
        int                  used;
        rtpl_pkg::rtpl_rsp_t awaited[$];
        int                  errors;
        int                  checked;
        int                  lpm_hits;
        int                  full_hits;

        function new();
            used = 0;
            errors = 0;
            checked = 0;
            lpm_hits = 0;
            full_hits = 0;
        endfunction

        task report(string what);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, what);
        endtask

        function bit covers(logic [31:0] key, logic [31:0] route_addr, logic [5:0] plen);
            logic [31:0] mask;
            if (plen == 6'd0)
                return 1'b1;
            if (plen > 6'd31)
                return key == route_addr;
            mask = ~(32'hFFFF_FFFF >> plen);
            return (key & mask) == (route_addr & mask);
        endfunction

        function rtpl_pkg::rtpl_rsp_t entry_result(logic [1:0] st, int pos);
            rtpl_pkg::rtpl_rsp_t r;
            r = '0;
            r.status = st;
            r.hit_slot = pos[5:0];
            r.hit_address = routes[pos].address;
            r.hit_prefix = routes[pos].prefix;
            r.hit_next_hop = routes[pos].next_hop;
            r.hit_distance = routes[pos].distance;
            r.hit_broken = routes[pos].broken;
            return r;
        endfunction

        function int find_exact(logic [31:0] key);
            for (int i = 0; i < used; i++)
                if (routes[i].address == key)
                    return i;
            return -1;
        endfunction

        // Apply one accepted request to the shadow table and queue its response.
        function void note_request(rtpl_pkg::rtpl_req_t q);
            rtpl_pkg::rtpl_rsp_t r;
            int pos;
            int best_len;
            r = '0;
            case (q.opcode)
                rtpl_pkg::OP_APPEND:
                    if (used >= ROUTE_SLOTS)
                    begin
                        r.status = rtpl_pkg::ST_FULL;
                        full_hits++;
                    end
                    else
                    begin
                        routes[used] = '{q.address, q.prefix_len, q.next_hop,
                                         q.distance, q.broken_in};
                        used++;
                        r = entry_result(rtpl_pkg::ST_OK, used - 1);
                    end
                rtpl_pkg::OP_DELETE:
                begin
                    pos = find_exact(q.address);
                    if (pos < 0)
                        r.status = rtpl_pkg::ST_NOTFOUND;
                    else
                    begin
                        r = entry_result(rtpl_pkg::ST_OK, pos);
                        for (int j = pos; j + 1 < used; j++)
                            routes[j] = routes[j + 1];
                        used--;
                    end
                end
                rtpl_pkg::OP_EXACT:
                begin
                    pos = find_exact(q.address);
                    if (pos < 0)
                        r.status = rtpl_pkg::ST_NOTFOUND;
                    else
                        r = entry_result(rtpl_pkg::ST_OK, pos);
                end
                rtpl_pkg::OP_LPM:
                begin
                    pos = -1;
                    best_len = 0;
                    for (int i = 0; i < used; i++)
                        if (int'(routes[i].prefix) > best_len &&
                            covers(q.address, routes[i].address, routes[i].prefix))
                        begin
                            best_len = routes[i].prefix;
                            pos = i;
                        end
                    if (pos < 0)
                        r.status = rtpl_pkg::ST_NOTFOUND;
                    else
                    begin
                        r = entry_result(rtpl_pkg::ST_OK, pos);
                        lpm_hits++;
                    end
                end
                rtpl_pkg::OP_READ:
                    if (int'(q.slot) < used)
                        r = entry_result(rtpl_pkg::ST_OK, q.slot);
                    else
                        r.status = rtpl_pkg::ST_RANGE;
                default:
                    r.status = rtpl_pkg::ST_OK;
            endcase
            r.entry_count = used[6:0];
            awaited = {awaited, r};
        endfunction

        // Compare one response with the oldest prediction, field by field.
        task check_result(rtpl_pkg::rtpl_rsp_t got);
            rtpl_pkg::rtpl_rsp_t exp;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected response %h", got));
                return;
            end
            exp = awaited.pop_front();
            checked++;
            if (got.status !== exp.status)
                report($sformatf("status %0d, expected %0d", got.status, exp.status));
            if (got.hit_slot !== exp.hit_slot)
                report($sformatf("hit_slot %0d, expected %0d", got.hit_slot, exp.hit_slot));
            if (got.hit_address !== exp.hit_address)
                report($sformatf("hit_address %h, expected %h",
                                 got.hit_address, exp.hit_address));
            if (got.hit_prefix !== exp.hit_prefix)
                report($sformatf("hit_prefix %0d, expected %0d",
                                 got.hit_prefix, exp.hit_prefix));
            if (got.hit_next_hop !== exp.hit_next_hop)
                report($sformatf("hit_next_hop %h, expected %h",
                                 got.hit_next_hop, exp.hit_next_hop));
            if (got.hit_distance !== exp.hit_distance)
                report($sformatf("hit_distance %0d, expected %0d",
                                 got.hit_distance, exp.hit_distance));
            if (got.hit_broken !== exp.hit_broken)
                report($sformatf("hit_broken %0d, expected %0d",
                                 got.hit_broken, exp.hit_broken));
            if (got.entry_count !== exp.entry_count)
                report($sformatf("entry_count %0d, expected %0d",
                                 got.entry_count, exp.entry_count));
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   quiet;
    int   idle_cycles;
    int   rsp_hold;
    RouteScoreboard table_sb;

    rtpl_if #(.payload_t(rtpl_pkg::rtpl_req_t)) req_ch ();
    rtpl_if #(.payload_t(rtpl_pkg::rtpl_rsp_t)) rsp_ch ();

    route_table_prefix_lookup dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        table_sb = new();
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Monitor both channels, check responses and watch for a stalled run.
    always @(posedge clk)
    begin
        if (rst_n && table_sb != null)
        begin
            if (req_ch.valid && req_ch.ready)
                table_sb.note_request(req_ch.data);
            if (rsp_ch.valid && rsp_ch.ready)
                table_sb.check_result(rsp_ch.data);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
        else
            idle_cycles <= 0;
    end

    // Response side: ready drops in random bursts; no new burst starts in the quiet tail.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_hold <= 0;
        else if (rsp_hold > 0)
        begin
            rsp_hold <= rsp_hold - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            rsp_hold <= $urandom_range(0, 11);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // Present one item, with an optional idle burst first, until it is taken.
    task send_item(rtpl_pkg::rtpl_req_t item);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= item;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    function rtpl_pkg::rtpl_req_t make_item(logic [2:0] op, logic [31:0] addr,
                                            logic [5:0] plen, logic [5:0] pos);
        rtpl_pkg::rtpl_req_t r;
        r.opcode = op;
        r.address = addr;
        r.prefix_len = plen;
        r.next_hop = $urandom;
        r.distance = 16'($urandom);
        r.broken_in = 1'($urandom);
        r.slot = pos;
        return r;
    endfunction

    // Lookup keys mostly come from stored routes, often with low bits disturbed.
    function logic [31:0] pick_key();
        logic [31:0] key;
        if (table_sb.used == 0 || $urandom_range(0, 4) == 0)
            return $urandom;
        key = table_sb.routes[$urandom_range(0, table_sb.used - 1)].address;
        if ($urandom_range(0, 1) == 0)
            key = key ^ ($urandom >> $urandom_range(0, 31));
        return key;
    endfunction

    // The first edge lets the monitor record the item taken at the last one.
    task wait_drained();
        @(posedge clk);
        while (table_sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rtpl_pkg::rtpl_req_t item;
        logic [2:0] op;
        int pick;
        quiet = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Directed: empty table misses, then extremes of every field.
        send_item(make_item(rtpl_pkg::OP_EXACT, 32'h0, 6'd0, 6'd0));
        send_item(make_item(rtpl_pkg::OP_LPM, 32'hFFFF_FFFF, 6'd0, 6'd0));
        send_item(make_item(rtpl_pkg::OP_READ, 32'h0, 6'd0, 6'd0));
        send_item(make_item(rtpl_pkg::OP_DELETE, 32'h0A00_0000, 6'd0, 6'd0));
        item = make_item(rtpl_pkg::OP_APPEND, 32'h0000_0000, 6'd0, 6'd0);
        item.next_hop = 32'h0;
        item.distance = 16'h0;
        item.broken_in = 1'b0;
        send_item(item);
        item = make_item(rtpl_pkg::OP_APPEND, 32'hFFFF_FFFF, 6'd63, 6'd63);
        item.next_hop = 32'hFFFF_FFFF;
        item.distance = 16'hFFFF;
        item.broken_in = 1'b1;
        send_item(item);
        send_item(make_item(rtpl_pkg::OP_APPEND, 32'h0A00_0000, 6'd8, 6'd0));
        send_item(make_item(rtpl_pkg::OP_APPEND, 32'h0A01_0000, 6'd16, 6'd0));
        send_item(make_item(rtpl_pkg::OP_APPEND, 32'h0A01_0203, 6'd32, 6'd0));
        send_item(make_item(rtpl_pkg::OP_APPEND, 32'h0A01_0000, 6'd24, 6'd0));
        // Longest prefix: exact host, /24 over an earlier /16, /8, and prefix 0 never.
        send_item(make_item(rtpl_pkg::OP_LPM, 32'h0A01_0203, 6'd0, 6'd0));
        send_item(make_item(rtpl_pkg::OP_LPM, 32'h0A01_0099, 6'd0, 6'd0));
        send_item(make_item(rtpl_pkg::OP_LPM, 32'h0AFF_0000, 6'd0, 6'd0));
        send_item(make_item(rtpl_pkg::OP_LPM, 32'h0B00_0000, 6'd0, 6'd0));
        send_item(make_item(rtpl_pkg::OP_LPM, 32'hFFFF_FFFF, 6'd0, 6'd0));
        send_item(make_item(rtpl_pkg::OP_EXACT, 32'h0A01_0000, 6'd0, 6'd0));
        send_item(make_item(rtpl_pkg::OP_READ, 32'h0, 6'd0, 6'd5));
        send_item(make_item(rtpl_pkg::OP_READ, 32'h0, 6'd0, 6'd6));
        send_item(make_item(rtpl_pkg::OP_READ, 32'h0, 6'd0, 6'd63));
        // Delete from the middle keeps order; then the unused opcodes.
        send_item(make_item(rtpl_pkg::OP_DELETE, 32'h0A01_0000, 6'd0, 6'd0));
        send_item(make_item(rtpl_pkg::OP_READ, 32'h0, 6'd0, 6'd3));
        for (int k = 5; k < 8; k++)
            send_item(make_item(3'(k), $urandom, 6'($urandom), 6'($urandom)));

        // Hold off until the table has answered everything so far.
        req_ch.valid <= 1'b0;
        wait_drained();
        @(posedge clk);

        // Random part: fill and drain phases with lookups mixed in.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            pick = $urandom_range(0, 99);
            if ((n / 150) % 2 == 0)
                op = pick < 55 ? rtpl_pkg::OP_APPEND : pick < 65 ? rtpl_pkg::OP_DELETE :
                     pick < 75 ? rtpl_pkg::OP_EXACT : pick < 92 ? rtpl_pkg::OP_LPM :
                     pick < 98 ? rtpl_pkg::OP_READ : 3'($urandom_range(5, 7));
            else
                op = pick < 15 ? rtpl_pkg::OP_APPEND : pick < 50 ? rtpl_pkg::OP_DELETE :
                     pick < 62 ? rtpl_pkg::OP_EXACT : pick < 85 ? rtpl_pkg::OP_LPM :
                     pick < 98 ? rtpl_pkg::OP_READ : 3'($urandom_range(5, 7));
            item = make_item(op, pick_key(), 6'($urandom_range(0, 63)), 6'($urandom));
            if (op == rtpl_pkg::OP_APPEND && $urandom_range(0, 3) != 0)
                item.prefix_len = 6'($urandom_range(0, 32));
            if (op == rtpl_pkg::OP_READ && $urandom_range(0, 3) != 0)
                item.slot = 6'($urandom_range(0, table_sb.used > 0 ? table_sb.used - 1 : 0));
            send_item(item);
        end
        req_ch.valid <= 1'b0;

        wait_drained();
        repeat (100) @(posedge clk);
        $display("Covered %0d responses: %0d longest-prefix hits, %0d appends to a full table.",
                 table_sb.checked, table_sb.lpm_hits, table_sb.full_hits);
        if (table_sb.errors == 0 && table_sb.awaited.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
design/rtpl_pkg.sv
design/rtpl_if.sv
design/rtpl_ctrl.sv
design/rtpl_dp.sv
design/route_table_prefix_lookup.sv
dv/route_table_prefix_lookup_test.sv
